### rtl/skf_pkg.sv
// Types and constants shared by the scalar Kalman filter.
package skf_pkg;

  localparam int unsigned DATA_W  = 32;
  localparam int unsigned GAIN_W  = 16;
  localparam int unsigned TOTAL_W = 48;

  typedef enum logic [0:0] {
    CFG_PROCESS_NOISE     = 1'b0,
    CFG_MEASUREMENT_NOISE = 1'b1
  } cfg_index_e;

  typedef struct packed {
    logic signed [DATA_W-1:0] measurement;
    logic                     series_end;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] innovation;
    logic signed [DATA_W-1:0] estimate;
    logic        [DATA_W-1:0] covariance;
    logic signed [DATA_W-1:0] mean_innovation;
    logic                     last;
    logic                     saturated;
  } out_item_t;

endpackage

### rtl/scalar_kalman_filter.sv
// Scalar Kalman filter with a shared divider and multiplier under a sequencer.
//
// One-dimensional Kalman filter with unit transition and observation in
// fixed point (FRAC_BITS fraction bits). Each transfer on the input channel
// carries one measurement and yields exactly one result holding the
// innovation, the updated estimate and covariance, and on the last sample of
// a series the mean innovation, after which the filter returns to estimate 0
// and covariance 1.0. The block works on one measurement at a time: an
// ordinary sample passes from its transfer through prediction, the sum,
// the 16 steps of the radix-2 gain division, the multiply, the estimate
// and covariance updates and the load into the output register. A sample
// that ends a series also passes through the mean innovation, which reuses
// the same divider for 48 steps over the 48-bit innovation total. When the
// gain would reach one, it is held just below one and the division is
// skipped. The output register lets a new measurement be taken while a result
// still waits; a further result waits in the sequencer until the output
// register is free. The configuration port is always ready, and the noise
// registers must only be written while no measurement is in progress. A
// measurement noise of zero is treated as one LSB.
module scalar_kalman_filter #(
  parameter int unsigned FRAC_BITS      = 16,
  parameter int unsigned MAX_SERIES_LEN = 65536
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  skf_pkg::in_item_t       in_data_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output skf_pkg::out_item_t      out_data_o,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  skf_pkg::cfg_index_e     cfg_index_i,
  input  logic [31:0]             cfg_data_i
);
  import skf_pkg::*;

  // Sample counter width follows the longest series length.
  localparam int unsigned CNT_W = $clog2(MAX_SERIES_LEN + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_SERIES_LEN);
  localparam logic [DATA_W-1:0] ONE_FX  = DATA_W'(64'd1 << FRAC_BITS);
  localparam logic [DATA_W-1:0] HALF_FX = DATA_W'(64'd1 << (FRAC_BITS - 1));
  localparam int unsigned ITER_W = $clog2(TOTAL_W);
  localparam int unsigned PROD_W = 51;

  typedef enum logic [3:0] {
    ST_IDLE, ST_PRED, ST_SUM, ST_DIV, ST_MUL_X, ST_UPD_X,
    ST_UPD_P, ST_MLOAD, ST_MDIV, ST_MEAN, ST_FIN
  } state_e;

  state_e state_q;

  // Configuration registers.
  logic [DATA_W-1:0] q_noise_q, r_noise_q;

  // Filter state.
  logic signed [DATA_W-1:0]  x_q;
  logic        [DATA_W-1:0]  p_q;
  logic signed [TOTAL_W-1:0] total_q;
  logic        [CNT_W-1:0]   count_q;

  // Per-sample working registers.
  logic signed [DATA_W-1:0] z_q;
  logic                     last_q;
  logic                     sat_q;
  logic        [DATA_W-1:0] ppred_q;
  logic signed [DATA_W-1:0] innov_q;
  logic signed [DATA_W-1:0] mean_q;
  logic                     neg_q;

  // Shared restoring divider: remainder, dividend/quotient shift register,
  // divisor and step counter.
  logic [DATA_W-1:0]  rem_q;
  logic [TOTAL_W-1:0] quo_q;
  logic [DATA_W-1:0]  div_q;
  logic [ITER_W-1:0]  iter_q;

  // Shared multiplier product register.
  logic signed [PROD_W-1:0] prod_q;

  out_item_t out_q;
  logic      out_valid_q;

  // ---------------------------------------------------------------------
  // Datapath.
  // ---------------------------------------------------------------------
  logic [DATA_W:0]          ppred_sum;
  logic [DATA_W-1:0]        ppred_clip;
  logic signed [DATA_W:0]   innov_raw;
  logic signed [DATA_W-1:0] innov_clip;
  logic                     innov_ovf;
  logic [DATA_W-1:0]        r_eff;
  logic [DATA_W:0]          s_sum;
  logic [DATA_W-1:0]        s_clip;

  assign ppred_sum  = {1'b0, p_q} + {1'b0, q_noise_q};
  assign ppred_clip = ppred_sum[DATA_W] ? '1 : ppred_sum[DATA_W-1:0];
  assign innov_raw  = $signed({z_q[DATA_W-1], z_q}) - $signed({x_q[DATA_W-1], x_q});
  assign innov_ovf  = innov_raw[DATA_W] != innov_raw[DATA_W-1];
  assign innov_clip = !innov_ovf ? innov_raw[DATA_W-1:0] :
                      innov_raw[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} :
                                          {1'b0, {(DATA_W-1){1'b1}}};
  assign r_eff  = (r_noise_q == '0) ? DATA_W'(1) : r_noise_q;
  assign s_sum  = {1'b0, ppred_q} + {1'b0, r_eff};
  assign s_clip = s_sum[DATA_W] ? '1 : s_sum[DATA_W-1:0];

  // One restoring division step per cycle.
  logic [DATA_W:0]   rem_shift;
  logic              rem_ge;
  logic [DATA_W-1:0] rem_next;

  assign rem_shift = {rem_q, quo_q[TOTAL_W-1]};
  assign rem_ge    = rem_shift >= {1'b0, div_q};
  assign rem_next  = rem_ge ? DATA_W'(rem_shift - {1'b0, div_q}) : rem_shift[DATA_W-1:0];

  // Shared 18 x 33 signed multiplier: gain times innovation, then
  // (1 - gain) times predicted covariance.
  logic [GAIN_W-1:0]        gain;
  logic signed [17:0]       mul_a;
  logic signed [DATA_W:0]   mul_b;
  logic signed [PROD_W-1:0] mul_p;

  assign gain = quo_q[GAIN_W-1:0];

  always_comb begin
    if (state_q == ST_MUL_X) begin
      mul_a = $signed({2'b00, gain});
      mul_b = $signed({innov_q[DATA_W-1], innov_q});
    end else begin
      mul_a = $signed({1'b0, 17'(17'h10000 - {1'b0, gain})});
      mul_b = $signed({1'b0, ppred_q});
    end
  end

  assign mul_p = mul_a * mul_b;

  // Estimate update with round half up.
  logic signed [PROD_W-1:0] prod_rnd;
  logic signed [34:0]       delta;
  logic signed [34:0]       x_sum;
  logic                     x_ovf;
  logic signed [DATA_W-1:0] x_clip;
  logic        [DATA_W-1:0] p_new;

  assign prod_rnd = prod_q + $signed(PROD_W'(32768));
  assign delta    = prod_rnd[PROD_W-1:16];
  assign x_sum    = $signed({{3{x_q[DATA_W-1]}}, x_q}) + delta;
  assign x_ovf    = (x_sum[34:31] != 4'b0000) && (x_sum[34:31] != 4'b1111);
  assign x_clip   = !x_ovf ? x_sum[DATA_W-1:0] :
                    x_sum[34] ? {1'b1, {(DATA_W-1){1'b0}}} :
                                {1'b0, {(DATA_W-1){1'b1}}};
  assign p_new    = prod_rnd[47:16];

  // Innovation total and sample count.
  logic signed [TOTAL_W:0]   total_sum;
  logic                      total_ovf;
  logic signed [TOTAL_W-1:0] total_clip;
  logic [TOTAL_W-1:0]        total_mag;

  assign total_sum  = $signed({total_q[TOTAL_W-1], total_q})
                    + $signed({{(TOTAL_W-DATA_W+1){innov_q[DATA_W-1]}}, innov_q});
  assign total_ovf  = total_sum[TOTAL_W] != total_sum[TOTAL_W-1];
  assign total_clip = !total_ovf ? total_sum[TOTAL_W-1:0] :
                      total_sum[TOTAL_W] ? {1'b1, {(TOTAL_W-1){1'b0}}} :
                                           {1'b0, {(TOTAL_W-1){1'b1}}};
  assign total_mag  = total_q[TOTAL_W-1] ? TOTAL_W'(-total_q) : TOTAL_W'(total_q);

  // Mean innovation: signed quotient from the magnitude quotient.
  logic                     mean_ovf;
  logic signed [DATA_W-1:0] mean_clip;

  always_comb begin
    if (!neg_q) begin
      mean_ovf  = |quo_q[TOTAL_W-1:DATA_W-1];
      mean_clip = mean_ovf ? {1'b0, {(DATA_W-1){1'b1}}} : quo_q[DATA_W-1:0];
    end else begin
      mean_ovf  = quo_q > TOTAL_W'(64'd1 << (DATA_W - 1));
      mean_clip = mean_ovf ? {1'b1, {(DATA_W-1){1'b0}}} : DATA_W'(-quo_q[DATA_W-1:0]);
    end
  end

  assign in_ready_o  = state_q == ST_IDLE;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign cfg_ready_o = 1'b1;

  // ---------------------------------------------------------------------
  // Sequencer, state and registered outputs.
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      q_noise_q   <= ONE_FX;
      r_noise_q   <= HALF_FX;
      x_q         <= '0;
      p_q         <= ONE_FX;
      total_q     <= '0;
      count_q     <= '0;
      z_q         <= '0;
      last_q      <= 1'b0;
      sat_q       <= 1'b0;
      ppred_q     <= '0;
      innov_q     <= '0;
      mean_q      <= '0;
      neg_q       <= 1'b0;
      rem_q       <= '0;
      quo_q       <= '0;
      div_q       <= '0;
      iter_q      <= '0;
      prod_q      <= '0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CFG_PROCESS_NOISE:     q_noise_q <= cfg_data_i;
          CFG_MEASUREMENT_NOISE: r_noise_q <= cfg_data_i;
          default: ;
        endcase
      end

      // In the final state the output register is handled below.
      if (out_valid_q && out_ready_i && state_q != ST_FIN) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            z_q     <= in_data_i.measurement;
            last_q  <= in_data_i.series_end;
            sat_q   <= 1'b0;
            state_q <= ST_PRED;
          end
        end
        ST_PRED: begin
          ppred_q <= ppred_clip;
          innov_q <= innov_clip;
          sat_q   <= sat_q | ppred_sum[DATA_W] | innov_ovf;
          state_q <= ST_SUM;
        end
        ST_SUM: begin
          sat_q <= sat_q | s_sum[DATA_W] | (s_clip == ppred_q);
          if (s_clip == ppred_q) begin
            // The gain would reach one: hold it just below.
            quo_q   <= TOTAL_W'({GAIN_W{1'b1}});
            state_q <= ST_MUL_X;
          end else begin
            rem_q   <= ppred_q;
            quo_q   <= '0;
            div_q   <= s_clip;
            iter_q  <= ITER_W'(GAIN_W - 1);
            state_q <= ST_DIV;
          end
        end
        ST_DIV: begin
          rem_q  <= rem_next;
          quo_q  <= {quo_q[TOTAL_W-2:0], rem_ge};
          iter_q <= iter_q - 1'b1;
          if (iter_q == '0) begin
            state_q <= ST_MUL_X;
          end
        end
        ST_MUL_X: begin
          prod_q  <= mul_p;
          state_q <= ST_UPD_X;
        end
        ST_UPD_X: begin
          x_q     <= x_clip;
          sat_q   <= sat_q | x_ovf;
          prod_q  <= mul_p;
          state_q <= ST_UPD_P;
        end
        ST_UPD_P: begin
          p_q     <= p_new;
          total_q <= total_clip;
          mean_q  <= '0;
          if (count_q < CNT_MAX) begin
            count_q <= CNT_W'(count_q + 1'b1);
            sat_q   <= sat_q | total_ovf;
          end else begin
            sat_q   <= 1'b1;
          end
          state_q <= last_q ? ST_MLOAD : ST_FIN;
        end
        ST_MLOAD: begin
          rem_q   <= '0;
          quo_q   <= total_mag;
          neg_q   <= total_q[TOTAL_W-1];
          div_q   <= DATA_W'(count_q);
          iter_q  <= ITER_W'(TOTAL_W - 1);
          state_q <= ST_MDIV;
        end
        ST_MDIV: begin
          rem_q  <= rem_next;
          quo_q  <= {quo_q[TOTAL_W-2:0], rem_ge};
          iter_q <= iter_q - 1'b1;
          if (iter_q == '0) begin
            state_q <= ST_MEAN;
          end
        end
        ST_MEAN: begin
          mean_q  <= mean_clip;
          sat_q   <= sat_q | mean_ovf;
          state_q <= ST_FIN;
        end
        ST_FIN: begin
          if (!out_valid_q || out_ready_i) begin
            out_q.innovation      <= innov_q;
            out_q.estimate        <= x_q;
            out_q.covariance      <= p_q;
            out_q.mean_innovation <= mean_q;
            out_q.last            <= last_q;
            out_q.saturated       <= sat_q;
            out_valid_q           <= 1'b1;
            if (last_q) begin
              x_q     <= '0;
              p_q     <= ONE_FX;
              total_q <= '0;
              count_q <= '0;
            end
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule
